// ===== hw/rtl/assert_macros.svh =====
// Assertion macros used by the top-level RTL file of the literal length scanner.
// Define ASSERT_OFF to compile every assertion away; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// Checked only while reset is released.
`define NLLS_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
        else $error("nlls assertion failed");

// Checked at every clock edge, reset included.
`define NLLS_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) (prop)) \
        else $error("nlls assertion failed");

`else

`define NLLS_ASSERT(lbl, clk, rst_n, prop)
`define NLLS_ASSERT_ALWAYS(lbl, clk, prop)

`endif

`endif

// ===== hw/rtl/nlls_pkg.sv =====
// Package of the numeric literal length scanner: field widths, character
// codes, mode and kind codes, scan phases and the scan control struct.
package nlls_pkg;

    localparam int CHAR_W          = 8;
    localparam int LEN_W           = 16;
    localparam int KIND_W          = 2;
    localparam int MODE_W          = 3;
    localparam int LENGTH_BITS_DEF = 16;

    localparam logic [CHAR_W-1:0] CH_NUL   = 8'h00;
    localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
    localparam logic [CHAR_W-1:0] CH_NINE  = 8'h39;
    localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
    localparam logic [CHAR_W-1:0] CH_DOT   = 8'h2E;
    localparam logic [CHAR_W-1:0] CH_IMAG  = 8'h69;

    localparam logic [MODE_W-1:0] MODE_DIGITS   = 3'd0;
    localparam logic [MODE_W-1:0] MODE_UNSIGNED = 3'd1;
    localparam logic [MODE_W-1:0] MODE_INTEGER  = 3'd2;
    localparam logic [MODE_W-1:0] MODE_FLOAT    = 3'd3;
    localparam logic [MODE_W-1:0] MODE_FLT_INT  = 3'd4;
    localparam logic [MODE_W-1:0] MODE_IMAG     = 3'd5;
    localparam logic [MODE_W-1:0] MODE_RESET    = MODE_INTEGER;

    localparam logic [KIND_W-1:0] KIND_NONE  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_INT   = 2'd1;
    localparam logic [KIND_W-1:0] KIND_FLOAT = 2'd2;
    localparam logic [KIND_W-1:0] KIND_IMAG  = 2'd3;

    typedef enum logic [3:0] {
        PH_START  = 4'd0,
        PH_MINUS  = 4'd1,
        PH_ZERO   = 4'd2,
        PH_DIGITS = 4'd3,
        PH_DOT    = 4'd4,
        PH_FRAC   = 4'd5,
        PH_DONE   = 4'd6
    } t_phase;

    typedef struct packed {
        t_phase              phase;
        logic [KIND_W-1:0]   kind;
    } t_scan_ctl;

endpackage

// ===== hw/rtl/nlls_char_if.sv =====
// Byte request channel of the literal length scanner.
// Depends on nlls_pkg for the character width.
interface nlls_char_if;
    import nlls_pkg::*;

    logic              valid;
    logic              ready;
    logic [CHAR_W-1:0] character;

    modport source (output valid, output character, input ready);
    modport sink   (input valid, input character, output ready);
endinterface

// ===== hw/rtl/nlls_result_if.sv =====
// Result request channel of the literal length scanner.
// Depends on nlls_pkg for the length and kind widths.
interface nlls_result_if;
    import nlls_pkg::*;

    logic              valid;
    logic              ready;
    logic [LEN_W-1:0]  match_length;
    logic [KIND_W-1:0] matched_kind;
    logic              length_saturated;

    modport source (output valid, output match_length, output matched_kind,
                    output length_saturated, input ready);
    modport sink   (input valid, input match_length, input matched_kind,
                    input length_saturated, output ready);
endinterface

// ===== hw/rtl/numeric_literal_length_scanner.sv =====
// Top level of the numeric literal length scanner: input register, scan
// state, result register and configuration. Uses nlls_pkg, nlls_step,
// nlls_char_if, nlls_result_if and assert_macros.svh.
//
//   Channel    Direction  Payload                                    Role
//   i_char     in         character (8)                              one byte
//   o_result   out        match_length (16), matched_kind (2),       one per string
//                         length_saturated (1)
//   i_cfg_we   in         i_cfg_wdata (3) = literal_mode             write only
//
// One byte is accepted every cycle unless a terminator in the input register
// stalls. A byte is held in the input register and is then folded into the
// scan state by the step logic; the terminating zero byte loads the result
// register. A waiting result stalls only a terminator in the input register;
// other bytes keep moving, and a terminator can be taken while a result waits.
// Reset (synchronous, active low) selects mode 2 and starts a fresh string.
`include "assert_macros.svh"

module numeric_literal_length_scanner #(
    parameter int LENGTH_BITS = nlls_pkg::LENGTH_BITS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    nlls_char_if.sink                   i_char,
    nlls_result_if.source               o_result,
    input  logic                        i_cfg_we,
    input  logic [nlls_pkg::MODE_W-1:0] i_cfg_wdata
);
    import nlls_pkg::*;

    // The length counter never needs more than the result field holds.
    localparam int CNT_W = (LENGTH_BITS < LEN_W) ? LENGTH_BITS : LEN_W;
    localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

    // Configuration.
    logic [MODE_W-1:0] r_mode;

    // Input register.
    logic              r_in_vld;
    logic [CHAR_W-1:0] r_char;

    // Scan state of the current string.
    t_scan_ctl         r_ctl;
    logic [CNT_W-1:0]  r_count;
    logic [CNT_W-1:0]  r_ipl;
    logic [CNT_W-1:0]  r_dlen;

    // Result register.
    logic              r_out_vld;
    logic [LEN_W-1:0]  r_len;
    logic [KIND_W-1:0] r_kind;
    logic              r_sat;

    // Step outputs.
    t_scan_ctl         n_ctl;
    logic [CNT_W-1:0]  n_count;
    logic [CNT_W-1:0]  n_ipl;
    logic [CNT_W-1:0]  n_dlen;

    logic              is_term;
    logic              fire;
    logic              load_out;

    nlls_step #(
        .CNT_W (CNT_W)
    ) u_step (
        .i_mode  (r_mode),
        .i_char  (r_char),
        .i_ctl   (r_ctl),
        .i_count (r_count),
        .i_ipl   (r_ipl),
        .i_dlen  (r_dlen),
        .o_ctl   (n_ctl),
        .o_count (n_count),
        .o_ipl   (n_ipl),
        .o_dlen  (n_dlen)
    );

    // A terminator may only be processed when the result register has room.
    assign is_term  = (r_char == CH_NUL);
    assign fire     = r_in_vld && (!is_term || !r_out_vld || o_result.ready);
    assign load_out = fire && is_term;

    assign i_char.ready = !r_in_vld || fire;

    assign o_result.valid            = r_out_vld;
    assign o_result.match_length     = r_len;
    assign o_result.matched_kind     = r_kind;
    assign o_result.length_saturated = r_sat;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= MODE_RESET;
        end else if (i_cfg_we) begin
            r_mode <= i_cfg_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (i_char.valid && i_char.ready) begin
            r_in_vld <= 1'b1;
            r_char   <= i_char.character;
        end else if (fire) begin
            r_in_vld <= 1'b0;
        end
    end

    // The scan state returns to the start of a string after each terminator.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl.phase <= PH_START;
            r_ctl.kind  <= KIND_NONE;
            r_count     <= '0;
            r_ipl       <= '0;
            r_dlen      <= '0;
        end else if (fire) begin
            if (is_term) begin
                r_ctl.phase <= PH_START;
                r_ctl.kind  <= KIND_NONE;
                r_count     <= '0;
                r_ipl       <= '0;
                r_dlen      <= '0;
            end else begin
                r_ctl   <= n_ctl;
                r_count <= n_count;
                r_ipl   <= n_ipl;
                r_dlen  <= n_dlen;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (load_out) begin
            r_out_vld <= 1'b1;
            r_len     <= LEN_W'(n_dlen);
            r_kind    <= n_ctl.kind;
            r_sat     <= (n_count == CNT_MAX);
        end else if (o_result.ready) begin
            r_out_vld <= 1'b0;
        end
    end

    // A reported length of zero always goes with kind none, and back.
    `NLLS_ASSERT(a_kind_len, i_clk, i_rst_n, r_out_vld |-> ((r_len == '0) == (r_kind == KIND_NONE)))
    // Processing a terminator never overwrites a result still waiting.
    `NLLS_ASSERT_ALWAYS(a_no_overwrite, i_clk, load_out |-> (!r_out_vld || o_result.ready))
    // After a terminator the next string starts from a clean state.
    `NLLS_ASSERT(a_restart, i_clk, i_rst_n, load_out |=> (r_ctl.phase == PH_START && r_count == '0))
    // Once decided, the count holds until the string ends.
    `NLLS_ASSERT(a_done_hold, i_clk, i_rst_n, (r_ctl.phase == PH_DONE && !load_out) |=> $stable(r_count))

endmodule

// ===== hw/rtl/nlls_step.sv =====
// Next-state logic of the scanner for one byte: phase, counts and decision.
// Depends on nlls_pkg for codes, phases and the scan control struct.
module nlls_step #(
    parameter int CNT_W = nlls_pkg::LEN_W
) (
    input  logic [nlls_pkg::MODE_W-1:0] i_mode,
    input  logic [nlls_pkg::CHAR_W-1:0] i_char,
    input  nlls_pkg::t_scan_ctl         i_ctl,
    input  logic [CNT_W-1:0]            i_count,
    input  logic [CNT_W-1:0]            i_ipl,
    input  logic [CNT_W-1:0]            i_dlen,
    output nlls_pkg::t_scan_ctl         o_ctl,
    output logic [CNT_W-1:0]            o_count,
    output logic [CNT_W-1:0]            o_ipl,
    output logic [CNT_W-1:0]            o_dlen
);
    import nlls_pkg::*;

    localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};
    localparam logic [CNT_W-1:0] CNT_ONE = CNT_W'(1);
    localparam logic [CNT_W-1:0] CNT_NIL = '0;

    function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] x);
        return (x == CNT_MAX) ? x : x + CNT_ONE;
    endfunction

    logic              is_dig;
    logic              dec;
    logic              int_done;
    logic [CNT_W-1:0]  dec_len;
    logic [KIND_W-1:0] dec_kind;
    t_phase            ph;

    assign is_dig = (i_char >= CH_ZERO) && (i_char <= CH_NINE);

    always_comb begin
        ph       = i_ctl.phase;
        dec      = 1'b0;
        int_done = 1'b0;
        dec_len  = CNT_NIL;
        dec_kind = KIND_NONE;
        o_ipl    = i_ipl;

        if (i_ctl.phase != PH_DONE) begin
            if (i_mode > MODE_IMAG) begin
                dec = 1'b1;
            end else if (i_mode == MODE_DIGITS) begin
                if (is_dig) begin
                    ph = PH_DIGITS;
                end else begin
                    dec      = 1'b1;
                    dec_len  = i_count;
                    dec_kind = KIND_INT;
                end
            end else begin
                unique case (i_ctl.phase)
                    PH_START: begin
                        priority if (i_char == CH_MINUS && i_mode >= MODE_INTEGER) begin
                            ph = PH_MINUS;
                        end else if (i_char == CH_ZERO) begin
                            ph = PH_ZERO;
                        end else if (is_dig) begin
                            ph = PH_DIGITS;
                        end else if (i_char == CH_IMAG && i_mode == MODE_IMAG) begin
                            dec      = 1'b1;
                            dec_len  = CNT_ONE;
                            dec_kind = KIND_IMAG;
                        end else begin
                            dec = 1'b1;
                        end
                    end
                    PH_MINUS: begin
                        priority if (i_char == CH_ZERO) begin
                            ph = PH_ZERO;
                        end else if (is_dig) begin
                            ph = PH_DIGITS;
                        end else begin
                            dec = 1'b1;
                        end
                    end
                    PH_ZERO: begin
                        if (is_dig) begin
                            dec = 1'b1;
                        end else begin
                            int_done = 1'b1;
                        end
                    end
                    PH_DIGITS: begin
                        if (!is_dig) begin
                            int_done = 1'b1;
                        end
                    end
                    PH_DOT: begin
                        priority if (is_dig) begin
                            ph = PH_FRAC;
                        end else if (i_mode == MODE_FLT_INT) begin
                            dec      = 1'b1;
                            dec_len  = i_ipl;
                            dec_kind = KIND_INT;
                        end else begin
                            dec = 1'b1;
                        end
                    end
                    PH_FRAC: begin
                        if (!is_dig) begin
                            dec = 1'b1;
                            if (i_mode == MODE_IMAG) begin
                                if (i_char == CH_IMAG) begin
                                    dec_len  = sat_inc(i_count);
                                    dec_kind = KIND_IMAG;
                                end
                            end else begin
                                dec_len  = i_count;
                                dec_kind = KIND_FLOAT;
                            end
                        end
                    end
                    default: begin
                        dec = 1'b1;
                    end
                endcase
            end

            // The integer part has ended on the current byte.
            if (int_done) begin
                o_ipl = i_count;
                priority if (i_mode <= MODE_INTEGER) begin
                    dec      = 1'b1;
                    dec_len  = i_count;
                    dec_kind = KIND_INT;
                end else if (i_char == CH_DOT) begin
                    ph = PH_DOT;
                end else if (i_mode == MODE_FLT_INT) begin
                    dec      = 1'b1;
                    dec_len  = i_count;
                    dec_kind = KIND_INT;
                end else if (i_mode == MODE_IMAG && i_char == CH_IMAG) begin
                    dec      = 1'b1;
                    dec_len  = sat_inc(i_count);
                    dec_kind = KIND_IMAG;
                end else begin
                    dec = 1'b1;
                end
            end
        end

        if (dec) begin
            o_ctl.phase = PH_DONE;
            o_ctl.kind  = (dec_len != CNT_NIL) ? dec_kind : KIND_NONE;
            o_dlen      = dec_len;
            o_count     = i_count;
        end else begin
            o_ctl.phase = ph;
            o_ctl.kind  = i_ctl.kind;
            o_dlen      = i_dlen;
            o_count     = (ph == PH_DONE) ? i_count : sat_inc(i_count);
        end
    end

endmodule
